// ===== rtl/elr_pkg.sv =====
// ----------------------------------------------------------------------------
// elr_pkg
// Shared widths, register codes and structs of the ellipse rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package elr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int CENTER_BITS   = 12;
    localparam int RADIUS_BITS   = 11;
    localparam int SQ_BITS       = 2 * RADIUS_BITS;
    localparam int DSQ_BITS      = SQ_BITS + 1;
    localparam int PROD_BITS     = DSQ_BITS + COORD_BITS;
    localparam int DEC_BITS      = 40;
    localparam int CMP_BITS      = DEC_BITS + 2;
    localparam int PIX_BITS      = 14;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int PIX_IDX_BITS  = 2;

    localparam logic [PIX_IDX_BITS-1:0] PIX_IDX_LAST = PIX_IDX_BITS'(3);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS_X = 2'd2,
        REG_RADIUS_Y = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MOVE_DIAG,
        MOVE_HORIZ,
        MOVE_VERT
    } move_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]        pos_x;
        logic signed [COORD_BITS:0]   pos_y;
        logic signed [DEC_BITS-1:0]   decision;
        logic                         finished;
    } state_t;

    typedef struct packed {
        logic                  restart;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SQ_BITS-1:0]    a2;
        logic [SQ_BITS-1:0]    b2;
        logic [PROD_BITS-1:0]  py;
        logic [PROD_BITS-1:0]  px;
    } step_op_t;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] px_pos;
        logic signed [PIX_BITS-1:0] px_neg;
        logic signed [PIX_BITS-1:0] py_pos;
        logic signed [PIX_BITS-1:0] py_neg;
        logic                       fin;
        logic                       empty;
    } pix_set_t;

endpackage

`default_nettype wire

// ===== rtl/elr_req_if.sv =====
// ----------------------------------------------------------------------------
// elr_req_if
// Step request channel: valid, ready and the restart bit.
// ----------------------------------------------------------------------------
`default_nettype none

interface elr_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/elr_pix_if.sv =====
// ----------------------------------------------------------------------------
// elr_pix_if
// Pixel result channel: valid, ready and one plotted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface elr_pix_if
    import elr_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic                       last_of_step;
    logic                       final_step;
    logic                       no_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_of_step,
                    output final_step, output no_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last_of_step,
                    input final_step, input no_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/elr_step.sv =====
// ----------------------------------------------------------------------------
// elr_step
// One decision step: move choice, next state and the four mirrored pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module elr_step
    import elr_pkg::*;
(
    input  step_op_t               op,
    input  state_t                 cur,
    input  logic [CENTER_BITS-1:0] cx,
    input  logic [CENTER_BITS-1:0] cy,
    output state_t                 nxt,
    output pix_set_t               set
);

    logic [DEC_BITS-1:0]        a2_d;
    logic [DEC_BITS-1:0]        b2_d;
    logic [DEC_BITS-1:0]        aa_d;
    logic [DEC_BITS-1:0]        bb_d;
    logic [DEC_BITS-1:0]        py_d;
    logic [DEC_BITS-1:0]        px_d;
    logic [DEC_BITS-1:0]        d_init;
    logic [DEC_BITS-1:0]        d_cur;
    logic [DEC_BITS-1:0]        px_inc;
    logic [DEC_BITS-1:0]        py_dec;
    logic [DEC_BITS-1:0]        d_next;
    logic signed [CMP_BITS-1:0] d_cmp;
    logic signed [CMP_BITS-1:0] d1;
    logic signed [CMP_BITS-1:0] d2;
    logic                       d1_pos;
    logic                       d2_neg;
    logic                       running;
    move_t                      move;
    logic [PIX_BITS-1:0]        cx_e;
    logic [PIX_BITS-1:0]        cy_e;
    logic [PIX_BITS-1:0]        x_e;
    logic [PIX_BITS-1:0]        y_e;

    assign a2_d   = DEC_BITS'(op.a2);
    assign b2_d   = DEC_BITS'(op.b2);
    assign aa_d   = a2_d << 1;
    assign bb_d   = b2_d << 1;
    assign py_d   = DEC_BITS'(op.py);
    assign px_d   = DEC_BITS'(op.px);

    // on restart y = b, so the registered y product is 2a^2*b
    assign d_init = a2_d + b2_d - py_d;
    assign d_cur  = op.restart ? d_init : $unsigned(cur.decision);

    assign d_cmp  = $signed({{(CMP_BITS-DEC_BITS){d_cur[DEC_BITS-1]}}, d_cur});
    assign d1     = (d_cmp <<< 1) + $signed({{(CMP_BITS-PROD_BITS){1'b0}}, op.py})
                    - $signed({{(CMP_BITS-SQ_BITS){1'b0}}, op.a2});
    assign d2     = (d_cmp <<< 1) - $signed({{(CMP_BITS-PROD_BITS){1'b0}}, op.px})
                    - $signed({{(CMP_BITS-SQ_BITS){1'b0}}, op.b2});
    assign d1_pos = !d1[CMP_BITS-1] && (d1 != '0);
    assign d2_neg = d2[CMP_BITS-1];

    always_comb
    begin
        if (d_cur == '0)
        begin
            move = MOVE_DIAG;
        end
        else if (d_cur[DEC_BITS-1])
        begin
            move = d1_pos ? MOVE_DIAG : MOVE_HORIZ;
        end
        else
        begin
            move = d2_neg ? MOVE_DIAG : MOVE_VERT;
        end
    end

    // products for x+1 and y-1 from the registered ones
    assign px_inc = px_d + bb_d;
    assign py_dec = py_d - aa_d;

    always_comb
    begin
        case (move)
            MOVE_DIAG:  d_next = d_cur + px_inc + b2_d + a2_d - py_dec;
            MOVE_HORIZ: d_next = d_cur + px_inc + b2_d;
            MOVE_VERT:  d_next = d_cur + a2_d - py_dec;
            default:    d_next = d_cur;
        endcase
    end

    assign running = op.restart || !cur.finished;

    always_comb
    begin
        nxt = cur;
        if (running)
        begin
            nxt.pos_x    = op.x;
            nxt.pos_y    = $signed({1'b0, op.y});
            nxt.decision = $signed(d_next);
            nxt.finished = 1'b0;
            if (move != MOVE_VERT)
            begin
                nxt.pos_x = op.x + COORD_BITS'(1);
            end
            if (move != MOVE_HORIZ)
            begin
                nxt.pos_y    = $signed({1'b0, op.y} - (COORD_BITS+1)'(1));
                nxt.finished = (op.y == '0);
            end
        end
    end

    assign cx_e = {{(PIX_BITS-CENTER_BITS){1'b0}}, cx};
    assign cy_e = {{(PIX_BITS-CENTER_BITS){1'b0}}, cy};
    assign x_e  = {{(PIX_BITS-COORD_BITS){1'b0}}, op.x};
    assign y_e  = {{(PIX_BITS-COORD_BITS){1'b0}}, op.y};

    assign set.px_pos = $signed(cx_e + x_e);
    assign set.px_neg = $signed(cx_e - x_e);
    assign set.py_pos = $signed(cy_e + y_e);
    assign set.py_neg = $signed(cy_e - y_e);
    assign set.fin    = running && nxt.finished;
    assign set.empty  = !running;

endmodule

`default_nettype wire

// ===== rtl/ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// ellipse_rasterizer
// Bresenham ellipse walker: one request steps the first quadrant arc and
// yields its four mirrored pixels, or one empty result once complete.
// ----------------------------------------------------------------------------
// a request moves through the input, product and result stages to its first pixel
// output: one pixel per cycle unless pix.ready stalls it; new requests are taken
//   while earlier ones are in flight; a finished ellipse gives one result per request
// the x and y products are registered one stage ahead of the decision update
// reset: config, valid and index registers clear to zero and the walker starts
//   finished, so requests without restart give the empty result
`default_nettype none

module ellipse_rasterizer
    import elr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    elr_req_if.sink                       req,
    elr_pix_if.source                     pix
);

    logic [CENTER_BITS-1:0] center_x_reg;
    logic [CENTER_BITS-1:0] center_y_reg;
    logic [RADIUS_BITS-1:0] radius_x_reg;
    logic [RADIUS_BITS-1:0] radius_y_reg;

    state_t                 state_reg;
    state_t                 state_next;

    // input stage
    logic                   a_valid_reg;
    logic                   a_restart_reg;
    logic [SQ_BITS-1:0]     a_a2_reg;
    logic [SQ_BITS-1:0]     a_b2_reg;

    // product stage
    logic                   b_valid_reg;
    step_op_t               b_op_reg;
    step_op_t               b_op_next;

    // result stage
    logic                   pix_valid_reg;
    logic [PIX_IDX_BITS-1:0] pix_idx_reg;
    pix_set_t               pix_set_reg;
    pix_set_t               pix_set_next;

    logic                   accept;
    logic                   a_adv;
    logic                   commit;
    logic                   pix_last;
    logic                   pix_take;
    logic [COORD_BITS-1:0]  x_eff;
    logic [COORD_BITS-1:0]  y_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= '0;
            radius_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: center_x_reg <= cfg_data[CENTER_BITS-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[CENTER_BITS-1:0];
                REG_RADIUS_X: radius_x_reg <= cfg_data[RADIUS_BITS-1:0];
                REG_RADIUS_Y: radius_y_reg <= cfg_data[RADIUS_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // the product stage loads only once empty, so it sees the committed state
    assign a_adv     = a_valid_reg && !b_valid_reg;
    assign req.ready = !a_valid_reg || !b_valid_reg;
    assign accept    = req.valid && req.ready;

    assign pix_last  = pix_set_reg.empty || (pix_idx_reg == PIX_IDX_LAST);
    assign pix_take  = pix_valid_reg && pix.ready;
    assign commit    = b_valid_reg && (!pix_valid_reg || (pix_take && pix_last));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_restart_reg <= req.restart;
            a_a2_reg      <= radius_x_reg * radius_x_reg;
            a_b2_reg      <= radius_y_reg * radius_y_reg;
        end
    end

    assign x_eff = a_restart_reg ? '0 : state_reg.pos_x;
    assign y_eff = a_restart_reg ? COORD_BITS'(radius_y_reg)
                                 : state_reg.pos_y[COORD_BITS-1:0];

    always_comb
    begin
        b_op_next.restart = a_restart_reg;
        b_op_next.x       = x_eff;
        b_op_next.y       = y_eff;
        b_op_next.a2      = a_a2_reg;
        b_op_next.b2      = a_b2_reg;
        b_op_next.py      = {a_a2_reg, 1'b0} * y_eff;
        b_op_next.px      = {a_b2_reg, 1'b0} * x_eff;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_op_reg <= b_op_next;
        end
    end

    elr_step u_step (
        .op  (b_op_reg),
        .cur (state_reg),
        .cx  (center_x_reg),
        .cy  (center_y_reg),
        .nxt (state_next),
        .set (pix_set_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pos_x    <= '0;
            state_reg.pos_y    <= '1;
            state_reg.decision <= '0;
            state_reg.finished <= 1'b1;
        end
        else if (commit)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            pix_set_reg <= pix_set_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            pix_valid_reg <= 1'b0;
            pix_idx_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_adv)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                b_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                pix_valid_reg <= 1'b1;
                pix_idx_reg   <= '0;
            end
            else if (pix_take)
            begin
                pix_idx_reg <= pix_idx_reg + PIX_IDX_BITS'(1);
                if (pix_last)
                begin
                    pix_valid_reg <= 1'b0;
                end
            end
        end
    end

    // mirrored order: (+x,+y), (-x,-y), (+x,-y), (-x,+y)
    always_comb
    begin
        case (pix_idx_reg)
            2'd0:
            begin
                pix.pixel_x = pix_set_reg.px_pos;
                pix.pixel_y = pix_set_reg.py_pos;
            end
            2'd1:
            begin
                pix.pixel_x = pix_set_reg.px_neg;
                pix.pixel_y = pix_set_reg.py_neg;
            end
            2'd2:
            begin
                pix.pixel_x = pix_set_reg.px_pos;
                pix.pixel_y = pix_set_reg.py_neg;
            end
            default:
            begin
                pix.pixel_x = pix_set_reg.px_neg;
                pix.pixel_y = pix_set_reg.py_pos;
            end
        endcase
        if (pix_set_reg.empty)
        begin
            pix.pixel_x = '0;
            pix.pixel_y = '0;
        end
    end

    assign pix.valid        = pix_valid_reg;
    assign pix.last_of_step = pix_last;
    assign pix.final_step   = pix_set_reg.fin;
    assign pix.no_pixel     = pix_set_reg.empty;

    // walker state moves only when a step is handed to the output
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(state_reg))
        else $error("walker state changed without a commit");

    // a step that found the ellipse complete yields the empty result
    a_empty_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !b_op_reg.restart && state_reg.finished) |=> (pix.valid && pix.no_pixel))
        else $error("completed ellipse did not give an empty result");

    // output drains after the last result unless a new step loads
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_take && pix_last && !commit) |=> !pix.valid)
        else $error("output stayed valid after the last result");

    // the product stage never loads over an item still waiting there
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !commit) |=> (b_valid_reg && $stable(b_op_reg)))
        else $error("pending step was overwritten");

endmodule

`default_nettype wire

// ===== sim/ellipse_rasterizer_test.sv =====
// ----------------------------------------------------------------------------
// ellipse_rasterizer_test
// Self-checking bench for the ellipse rasterizer. A directed table covers
// reset, zero and full-scale registers, live register changes mid-walk and
// the three move kinds. Random walks with random stalls on both channels
// follow. Every pixel is checked against a bit-accurate walker or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_rasterizer_test;
    import elr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS         = 450;
    localparam int WALK_CAP      = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] px;
        logic signed [PIX_BITS-1:0] py;
        logic                       last;
        logic                       fin;
        logic                       empty;
    } pixel_t;

    typedef enum logic {
        ROW_CFG,
        ROW_STEP
    } row_kind_t;

    // n_typed = 0 means the pixels come from the walker; typed rows sit at the origin
    typedef struct packed {
        row_kind_t                kind;
        cfg_reg_t                 idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic                     restart;
        logic [2:0]               n_typed;
        logic                     t_fin;
        logic                     t_empty;
    } row_t;

    localparam row_t PLAN [38] = '{
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd1, 1'b0, 1'b1},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd1, 1'b0, 1'b1},
        // zero radii: a single dot at the origin, done in one step
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b1, 3'd4, 1'b1, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd1, 1'b0, 1'b1},
        '{ROW_CFG,  REG_CENTER_X, 12'hFFF,   1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CENTER_Y, 12'hFFF,   1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_RADIUS_X, 12'hFFF,   1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_RADIUS_Y, 12'h7FF,   1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b1, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        // centre moved mid-walk, negative mirrored coordinates
        '{ROW_CFG,  REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CENTER_Y, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        // flat ellipse: horizontal, diagonal and vertical moves
        '{ROW_CFG,  REG_CENTER_X, 12'd100,   1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CENTER_Y, 12'd60,    1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_RADIUS_X, 12'd6,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_RADIUS_Y, 12'd2,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b1, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        // restart in the middle of a walk
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b1, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        // zero vertical radius: one vertical move ends it
        '{ROW_CFG,  REG_RADIUS_X, 12'd5,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_RADIUS_Y, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b1, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0},
        '{ROW_STEP, REG_CENTER_X, 12'd0,     1'b0, 3'd0, 1'b0, 1'b0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    elr_req_if req_ch ();
    elr_pix_if pix_ch ();

    ellipse_rasterizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .pix       (pix_ch)
    );

    // register copies and walker state
    logic [CENTER_BITS-1:0]     cur_cx;
    logic [CENTER_BITS-1:0]     cur_cy;
    logic [RADIUS_BITS-1:0]     cur_rx;
    logic [RADIUS_BITS-1:0]     cur_ry;
    logic [COORD_BITS-1:0]      walk_x;
    logic signed [COORD_BITS:0] walk_y;
    logic signed [DEC_BITS-1:0] walk_d;
    logic                       walk_done;

    pixel_t pixel_q [$];
    int     items_sent = 0;
    int     cycles = 0;
    logic   calm = 1'b0;
    logic   failed = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        // switch between stretches with and without idling
        if (cycles % 256 == 255)
        begin
            calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // one step of the quadrant walk, pixels in emission order
    task automatic walk_step(input logic restart, output pixel_t res [4], output int n);
        longint a, b, a2, b2, aa, bb, cx, cy, x, y, d;
        logic go_diag, go_horiz;
        logic signed [PIX_BITS-1:0] xp, xn, yp, yn;
        a  = longint'(cur_rx);
        b  = longint'(cur_ry);
        a2 = a * a;
        b2 = b * b;
        aa = 2 * a2;
        bb = 2 * b2;
        cx = longint'(cur_cx);
        cy = longint'(cur_cy);
        if (restart)
        begin
            walk_x    = '0;
            walk_y    = (COORD_BITS+1)'(b);
            walk_d    = DEC_BITS'(a2 + b2 - aa * b);
            walk_done = 1'b0;
        end
        if (walk_done)
        begin
            res[0] = '{px: '0, py: '0, last: 1'b1, fin: 1'b0, empty: 1'b1};
            n = 1;
        end
        else
        begin
            x  = longint'(walk_x);
            y  = longint'(walk_y);
            d  = longint'(walk_d);
            xp = PIX_BITS'(cx + x);
            xn = PIX_BITS'(cx - x);
            yp = PIX_BITS'(cy + y);
            yn = PIX_BITS'(cy - y);
            go_diag  = 1'b0;
            go_horiz = 1'b0;
            if (d == 0)
            begin
                go_diag = 1'b1;
            end
            else if (d < 0)
            begin
                if (2 * d + y * aa - a2 > 0)
                begin
                    go_diag = 1'b1;
                end
                else
                begin
                    go_horiz = 1'b1;
                end
            end
            else if (2 * d - bb * x - b2 < 0)
            begin
                go_diag = 1'b1;
            end
            if (go_diag)
            begin
                x = x + 1;
                y = y - 1;
                d = d + bb * x + b2 + a2 - aa * y;
            end
            else if (go_horiz)
            begin
                x = x + 1;
                d = d + bb * x + b2;
            end
            else
            begin
                y = y - 1;
                d = d + a2 - aa * y;
            end
            walk_x = COORD_BITS'(x);
            walk_y = (COORD_BITS+1)'(y);
            walk_d = DEC_BITS'(d);
            if (y < 0)
            begin
                walk_done = 1'b1;
            end
            res[0] = '{px: xp, py: yp, last: 1'b0, fin: walk_done, empty: 1'b0};
            res[1] = '{px: xn, py: yn, last: 1'b0, fin: walk_done, empty: 1'b0};
            res[2] = '{px: xp, py: yn, last: 1'b0, fin: walk_done, empty: 1'b0};
            res[3] = '{px: xn, py: yp, last: 1'b1, fin: walk_done, empty: 1'b0};
            n = 4;
        end
    endtask

    task automatic send_step(input logic restart, input int n_typed, input logic t_fin,
                             input logic t_empty);
        pixel_t res [4];
        int     n;
        int     gap;
        cfg_we         <= 1'b0;
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        walk_step(restart, res, n);
        if (n_typed == 0)
        begin
            for (int k = 0; k < n; k++)
            begin
                pixel_q.push_back(res[k]);
            end
        end
        else
        begin
            for (int k = 0; k < n_typed; k++)
            begin
                pixel_q.push_back('{px: '0, py: '0, last: (k == n_typed - 1),
                                    fin: t_fin, empty: t_empty});
            end
        end
        items_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every pixel is back and the block has drained
    task automatic settle();
        req_ch.valid <= 1'b0;
        cfg_we       <= 1'b0;
        while (pixel_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_we stays high across back-to-back writes, lowered by the next step or settle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_CENTER_X: cur_cx = data;
            REG_CENTER_Y: cur_cy = data;
            REG_RADIUS_X: cur_rx = data[RADIUS_BITS-1:0];
            REG_RADIUS_Y: cur_ry = data[RADIUS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic run_walk(input logic first_restart);
        int n;
        send_step(first_restart, 0, 1'b0, 1'b0);
        n = 1;
        while (!walk_done && n < WALK_CAP)
        begin
            send_step(1'b0, 0, 1'b0, 1'b0);
            n++;
        end
        repeat ($urandom_range(0, 2)) send_step(1'b0, 0, 1'b0, 1'b0);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] edge_radius();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return 12'd1;
            default: return 12'hFFF;
        endcase
    endfunction

    // pixel checker and output stalls
    initial
    begin
        pixel_t want;
        int     stall_left;
        stall_left   = 0;
        pix_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_ch.valid && pix_ch.ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("unexpected pixel x=%0d y=%0d", pix_ch.pixel_x, pix_ch.pixel_y);
                    failed = 1'b1;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (want.px !== pix_ch.pixel_x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.px, pix_ch.pixel_x);
                        failed = 1'b1;
                    end
                    if (want.py !== pix_ch.pixel_y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.py, pix_ch.pixel_y);
                        failed = 1'b1;
                    end
                    if (want.last !== pix_ch.last_of_step)
                    begin
                        $error("last_of_step: expected %0b, got %0b", want.last,
                               pix_ch.last_of_step);
                        failed = 1'b1;
                    end
                    if (want.fin !== pix_ch.final_step)
                    begin
                        $error("final_step: expected %0b, got %0b", want.fin,
                               pix_ch.final_step);
                        failed = 1'b1;
                    end
                    if (want.empty !== pix_ch.no_pixel)
                    begin
                        $error("no_pixel: expected %0b, got %0b", want.empty,
                               pix_ch.no_pixel);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0)
            begin
                pix_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pix_ch.ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    initial
    begin
        int style;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        cur_cx         = '0;
        cur_cy         = '0;
        cur_rx         = '0;
        cur_ry         = '0;
        walk_x         = '0;
        walk_y         = '1;
        walk_d         = '0;
        walk_done      = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(PLAN); i++)
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(PLAN[i].idx, PLAN[i].data);
            end
            else
            begin
                send_step(PLAN[i].restart, int'(PLAN[i].n_typed), PLAN[i].t_fin,
                          PLAN[i].t_empty);
            end
        end

        while (items_sent < ITEMS)
        begin
            settle();
            style = $urandom_range(0, 9);
            if (style == 2)
            begin
                // live register change, then carry on with the same walk
                write_reg(cfg_reg_t'($urandom_range(0, 3)),
                          CFG_DATA_BITS'($urandom_range(0, 4095)));
                run_walk(1'b0);
            end
            else
            begin
                case (style)
                    0:
                    begin
                        write_reg(REG_CENTER_X, $urandom_range(0, 1) ? 12'hFFF : 12'h000);
                        write_reg(REG_CENTER_Y, $urandom_range(0, 1) ? 12'hFFF : 12'h000);
                        write_reg(REG_RADIUS_X, edge_radius());
                        write_reg(REG_RADIUS_Y, edge_radius());
                    end
                    1:
                    begin
                        write_reg(REG_CENTER_X, CFG_DATA_BITS'($urandom_range(0, 4095)));
                        write_reg(REG_CENTER_Y, CFG_DATA_BITS'($urandom_range(0, 4095)));
                        write_reg(REG_RADIUS_X, CFG_DATA_BITS'($urandom_range(0, 4095)));
                        write_reg(REG_RADIUS_Y, CFG_DATA_BITS'($urandom_range(0, 4095)));
                    end
                    default:
                    begin
                        write_reg(REG_CENTER_X, CFG_DATA_BITS'($urandom_range(0, 4095)));
                        write_reg(REG_CENTER_Y, CFG_DATA_BITS'($urandom_range(0, 4095)));
                        write_reg(REG_RADIUS_X, CFG_DATA_BITS'($urandom_range(0, 24)));
                        write_reg(REG_RADIUS_Y, CFG_DATA_BITS'($urandom_range(0, 24)));
                    end
                endcase
                if ($urandom_range(0, 9) < 8)
                begin
                    run_walk(1'b1);
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        send_step($urandom_range(0, 3) == 0, 0, 1'b0, 1'b0);
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (!failed && pixel_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
